### rtl/core/mseu_pkg.sv
// mseu_pkg: shared types, opcodes and constants of the mips subset execute unit
// used by every module under rtl/core except mseu_regfile
`default_nettype none
package mseu_pkg;

	localparam int DATA_WORDS_DEF = 1024;
	localparam logic [31:0] RETURN_MARKER = 32'hDEADBEEF;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LH      = 6'd33;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SH      = 6'd41;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL  = 6'd0;
	localparam logic [5:0] FN_SRA  = 6'd3;
	localparam logic [5:0] FN_SLLV = 6'd4;
	localparam logic [5:0] FN_JR   = 6'd8;
	localparam logic [5:0] FN_JALR = 6'd9;
	localparam logic [5:0] FN_MFHI = 6'd16;
	localparam logic [5:0] FN_MFLO = 6'd18;
	localparam logic [5:0] FN_MULT = 6'd24;
	localparam logic [5:0] FN_DIV  = 6'd26;
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SUB  = 6'd34;
	localparam logic [5:0] FN_SUBU = 6'd35;
	localparam logic [5:0] FN_AND  = 6'd36;
	localparam logic [5:0] FN_OR   = 6'd37;
	localparam logic [5:0] FN_XOR  = 6'd38;
	localparam logic [5:0] FN_SLT  = 6'd42;

	localparam logic [4:0] RT_BGEZ = 5'd1;
	localparam logic [4:0] REG_RA  = 5'd31;

	typedef struct packed {
		logic        mode;
		logic [31:0] instruction_word;
		logic [31:0] start_address;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] fetch_address;
		logic        finished;
		logic        invalid_op;
		logic        store_valid;
		logic        store_half;
		logic [31:0] store_address;
		logic [31:0] store_data;
	} res_item_t;

	typedef struct packed {
		logic        start;
		logic        div;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_rsp_t;

endpackage
`default_nettype wire

### rtl/core/mseu_regfile.sv
// mseu_regfile: 32 x 32 register file, two registered read ports, one write port
// r0 never written; per-entry valid bits give the all-zero reset; does not use mseu_pkg
`default_nettype none
module mseu_regfile (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [4:0]  rd_a,
	input  wire logic [4:0]  rd_b,
	output logic      [31:0] rdata_a,
	output logic      [31:0] rdata_b,
	input  wire logic        wr_en,
	input  wire logic [4:0]  wr_a,
	input  wire logic [31:0] wr_data
);
	logic [31:0] mem_q [32];
	logic [31:0] vld_q;
	logic [31:0] rdata_a_q;
	logic [31:0] rdata_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en && wr_a != 5'd0) begin
			vld_q[wr_a] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_a != 5'd0) begin
			mem_q[wr_a] <= wr_data;
		end
		if (rd_en) begin
			rdata_a_q <= vld_q[rd_a] ? mem_q[rd_a] : 32'd0;
			rdata_b_q <= vld_q[rd_b] ? mem_q[rd_b] : 32'd0;
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule
`default_nettype wire

### rtl/core/mseu_muldiv.sv
// mseu_muldiv: shared iterative unit, radix-2 shift-add multiply and restoring divide
// 32 steps plus a sign fix-up step; uses mseu_pkg request and response types
`default_nettype none
module mseu_muldiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mseu_pkg::md_req_t req,
	output mseu_pkg::md_rsp_t      rsp
);
	localparam logic [1:0] MD_IDLE = 2'd0;
	localparam logic [1:0] MD_RUN  = 2'd1;
	localparam logic [1:0] MD_FIN  = 2'd2;

	logic [1:0]  state_q;
	logic [4:0]  cnt_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] opd_q;
	logic        div_q;
	logic        neg_lo_q;
	logic        neg_hi_q;
	logic        done_q;
	logic [31:0] res_hi_q;
	logic [31:0] res_lo_q;

	logic        sa;
	logic        sb;
	logic [31:0] a_abs;
	logic [31:0] b_abs;
	logic [32:0] msum;
	logic [32:0] dshift;
	logic [33:0] ddiff;
	logic [63:0] prod_neg;

	always_comb begin
		sa = req.sgn & req.a[31];
		sb = req.sgn & req.b[31];
		a_abs = sa ? (32'd0 - req.a) : req.a;
		b_abs = sb ? (32'd0 - req.b) : req.b;
		msum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, opd_q}) : {1'b0, hi_q};
		dshift = {hi_q, lo_q[31]};
		ddiff = {1'b0, dshift} - {2'b00, opd_q};
		prod_neg = 64'd0 - {hi_q, lo_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_RUN;
						cnt_q <= '0;
					end
				end
				MD_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= MD_FIN;
					end
				end
				MD_FIN: begin
					state_q <= MD_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			hi_q <= '0;
			lo_q <= a_abs;
			opd_q <= b_abs;
			div_q <= req.div;
			neg_lo_q <= sa ^ sb;
			neg_hi_q <= req.div ? sa : (sa ^ sb);
		end else if (state_q == MD_RUN) begin
			if (div_q) begin
				hi_q <= ddiff[33] ? dshift[31:0] : ddiff[31:0];
				lo_q <= {lo_q[30:0], ~ddiff[33]};
			end else begin
				hi_q <= msum[32:1];
				lo_q <= {msum[0], lo_q[31:1]};
			end
		end else if (state_q == MD_FIN) begin
			if (div_q) begin
				res_lo_q <= neg_lo_q ? (32'd0 - lo_q) : lo_q;
				res_hi_q <= neg_hi_q ? (32'd0 - hi_q) : hi_q;
			end else begin
				res_lo_q <= neg_lo_q ? prod_neg[31:0] : lo_q;
				res_hi_q <= neg_lo_q ? prod_neg[63:32] : hi_q;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi = res_hi_q;
	assign rsp.lo = res_lo_q;
endmodule
`default_nettype wire

### rtl/core/mseu_dmem.sv
// mseu_dmem: data memory of DATA_WORDS words, registered read, one write port
// clears itself after reset one word a cycle; uses mseu_pkg for the default depth
`default_nettype none
module mseu_dmem #(
	parameter int DATA_WORDS = mseu_pkg::DATA_WORDS_DEF,
	parameter int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	output logic               busy,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_idx,
	output logic      [31:0]   rdata,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_idx,
	input  wire logic [31:0]   wr_data
);
	localparam logic [AW-1:0] LAST = AW'(DATA_WORDS - 1);

	logic [31:0]   mem_q [DATA_WORDS];
	logic          busy_q;
	logic [AW-1:0] clr_q;
	logic [31:0]   rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_idx];
		end
	end

	assign busy = busy_q;
	assign rdata = rdata_q;
endmodule
`default_nettype wire

### rtl/core/mips_subset_execute_unit_core.sv
// mips_subset_execute_unit_core: sequencer of the execute unit, holds pc, hi, lo
// load/store reduce the index on the shared divider when DATA_WORDS is not a power of
// two; mult/div also use the shared divider
// one item at a time, next item can be accepted in the same cycle the result is presented
// reset: arst_n clears control state; then the data memory clearing pass stalls cmd
// uses mseu_pkg, mseu_regfile, mseu_muldiv, mseu_dmem
`default_nettype none
module mips_subset_execute_unit_core #(
	parameter int DATA_WORDS = mseu_pkg::DATA_WORDS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire mseu_pkg::cmd_item_t cmd,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output mseu_pkg::res_item_t      res
);
	localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam bit POW2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_EXEC  = 4'd2;
	localparam logic [3:0] ST_MD    = 4'd3;
	localparam logic [3:0] ST_IDX   = 4'd4;
	localparam logic [3:0] ST_MRD   = 4'd5;
	localparam logic [3:0] ST_MEM   = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;

	localparam logic [1:0] K_SIMPLE = 2'd0;
	localparam logic [1:0] K_MD     = 2'd1;
	localparam logic [1:0] K_MEM    = 2'd2;

	logic [3:0]          state_q;
	mseu_pkg::cmd_item_t cmd_q;
	logic [31:0]         pc_q;
	logic [31:0]         ds_q;
	logic [31:0]         hi_q;
	logic [31:0]         lo_q;
	logic [31:0]         ea_q;
	logic [AW-1:0]       idx_q;
	logic                inv_q;
	logic                st_valid_q;
	logic                st_half_q;
	logic [31:0]         st_addr_q;
	logic [31:0]         st_data_q;
	mseu_pkg::res_item_t res_q;
	logic                res_valid_q;

	logic        accept;
	logic        dm_busy;
	logic [31:0] rs_d;
	logic [31:0] rt_d;
	logic [31:0] dm_rdata;
	mseu_pkg::md_req_t md_req;
	mseu_pkg::md_rsp_t md_rsp;

	logic [31:0] ins;
	logic [5:0]  op;
	logic [4:0]  rtn;
	logic [4:0]  rdn;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [31:0] imm_u;
	logic [31:0] imm_s;
	logic [31:0] ea;
	logic [31:0] btarget;
	logic        is_load;

	logic        ex_inv;
	logic        ex_we;
	logic [4:0]  ex_wa;
	logic [31:0] ex_wd;
	logic [31:0] ex_ds;
	logic [1:0]  ex_kind;

	logic        rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;
	logic [15:0] ld_half;
	logic        dm_we;
	logic [31:0] dm_wd;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE) || dm_busy;

	always_comb begin
		ins = cmd_q.instruction_word;
		op = ins[31:26];
		rtn = ins[20:16];
		rdn = ins[15:11];
		sh = ins[10:6];
		fn = ins[5:0];
		imm_u = {16'd0, ins[15:0]};
		imm_s = {{16{ins[15]}}, ins[15:0]};
		ea = rs_d + imm_s;
		btarget = ds_q + {imm_s[29:0], 2'b00};
		is_load = (op == mseu_pkg::OP_LH) || (op == mseu_pkg::OP_LW);
	end

	always_comb begin
		ex_inv = 1'b0;
		ex_we = 1'b0;
		ex_wa = rtn;
		ex_wd = '0;
		ex_ds = ds_q + 32'd4;
		ex_kind = K_SIMPLE;
		unique case (op)
			mseu_pkg::OP_SPECIAL: begin
				ex_wa = rdn;
				ex_we = 1'b1;
				unique case (fn)
					mseu_pkg::FN_SLL:  ex_wd = rt_d << sh;
					mseu_pkg::FN_SRA:  ex_wd = $unsigned($signed(rt_d) >>> sh);
					mseu_pkg::FN_SLLV: ex_wd = rt_d << rs_d[4:0];
					mseu_pkg::FN_JR: begin
						ex_we = 1'b0;
						ex_ds = rs_d;
					end
					mseu_pkg::FN_JALR: begin
						ex_wd = ds_q + 32'd4;
						ex_ds = rs_d;
					end
					mseu_pkg::FN_MFHI: ex_wd = hi_q;
					mseu_pkg::FN_MFLO: ex_wd = lo_q;
					mseu_pkg::FN_MULT, mseu_pkg::FN_DIV: begin
						ex_we = 1'b0;
						ex_kind = K_MD;
					end
					mseu_pkg::FN_ADDU: ex_wd = rs_d + rt_d;
					mseu_pkg::FN_SUB, mseu_pkg::FN_SUBU: ex_wd = rs_d - rt_d;
					mseu_pkg::FN_AND:  ex_wd = rs_d & rt_d;
					mseu_pkg::FN_OR:   ex_wd = rs_d | rt_d;
					mseu_pkg::FN_XOR:  ex_wd = rs_d ^ rt_d;
					mseu_pkg::FN_SLT:  ex_wd = {31'd0, $signed(rs_d) < $signed(rt_d)};
					default: begin
						ex_we = 1'b0;
						ex_inv = 1'b1;
					end
				endcase
			end
			mseu_pkg::OP_REGIMM: begin
				if (rtn == mseu_pkg::RT_BGEZ) begin
					if (!rs_d[31]) begin
						ex_ds = btarget;
					end
				end else begin
					ex_inv = 1'b1;
				end
			end
			mseu_pkg::OP_BEQ: begin
				if (rs_d == rt_d) begin
					ex_ds = btarget;
				end
			end
			mseu_pkg::OP_BNE: begin
				if (rs_d != rt_d) begin
					ex_ds = btarget;
				end
			end
			mseu_pkg::OP_ADDIU: begin
				ex_we = 1'b1;
				ex_wd = rs_d + imm_s;
			end
			mseu_pkg::OP_SLTI: begin
				ex_we = 1'b1;
				ex_wd = {31'd0, $signed(rs_d) < $signed(imm_s)};
			end
			mseu_pkg::OP_SLTIU: begin
				ex_we = 1'b1;
				ex_wd = {31'd0, rs_d < imm_s};
			end
			mseu_pkg::OP_ANDI: begin
				ex_we = 1'b1;
				ex_wd = rs_d & imm_u;
			end
			mseu_pkg::OP_ORI: begin
				ex_we = 1'b1;
				ex_wd = rs_d | imm_u;
			end
			mseu_pkg::OP_XORI: begin
				ex_we = 1'b1;
				ex_wd = rs_d ^ imm_u;
			end
			mseu_pkg::OP_LUI: begin
				ex_we = 1'b1;
				ex_wd = {ins[15:0], 16'd0};
			end
			mseu_pkg::OP_LH, mseu_pkg::OP_LW, mseu_pkg::OP_SH, mseu_pkg::OP_SW: begin
				ex_kind = K_MEM;
			end
			default: begin
				ex_inv = 1'b1;
			end
		endcase
	end

	always_comb begin
		md_req.start = 1'b0;
		md_req.div = 1'b1;
		md_req.sgn = 1'b1;
		md_req.a = rs_d;
		md_req.b = rt_d;
		if (state_q == ST_EXEC && !ex_inv) begin
			if (ex_kind == K_MD) begin
				md_req.start = 1'b1;
				md_req.div = (fn == mseu_pkg::FN_DIV);
			end else if (ex_kind == K_MEM && !POW2) begin
				md_req.start = 1'b1;
				md_req.sgn = 1'b0;
				md_req.a = {2'b00, ea[31:2]};
				md_req.b = 32'(DATA_WORDS);
			end
		end
	end

	always_comb begin
		ld_half = ea_q[1] ? dm_rdata[31:16] : dm_rdata[15:0];
		rf_we = 1'b0;
		rf_wa = ex_wa;
		rf_wd = ex_wd;
		unique case (state_q)
			ST_START: begin
				rf_we = 1'b1;
				rf_wa = mseu_pkg::REG_RA;
				rf_wd = mseu_pkg::RETURN_MARKER;
			end
			ST_EXEC: begin
				rf_we = ex_we && !ex_inv;
			end
			ST_MEM: begin
				rf_we = is_load;
				rf_wa = rtn;
				rf_wd = (op == mseu_pkg::OP_LW) ? dm_rdata : {{16{ld_half[15]}}, ld_half};
			end
			default: begin
				rf_we = 1'b0;
			end
		endcase
		dm_we = (state_q == ST_MEM) && !is_load;
		if (op == mseu_pkg::OP_SW) begin
			dm_wd = rt_d;
		end else if (ea_q[1]) begin
			dm_wd = {rt_d[15:0], dm_rdata[15:0]};
		end else begin
			dm_wd = {dm_rdata[31:16], rt_d[15:0]};
		end
	end

	mseu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_a    (cmd.instruction_word[25:21]),
		.rd_b    (cmd.instruction_word[20:16]),
		.rdata_a (rs_d),
		.rdata_b (rt_d),
		.wr_en   (rf_we),
		.wr_a    (rf_wa),
		.wr_data (rf_wd)
	);

	mseu_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	mseu_dmem #(
		.DATA_WORDS (DATA_WORDS),
		.AW         (AW)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (dm_busy),
		.rd_en   (state_q == ST_MRD),
		.rd_idx  (idx_q),
		.rdata   (dm_rdata),
		.wr_en   (dm_we),
		.wr_idx  (idx_q),
		.wr_data (dm_wd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			ds_q <= 32'd4;
			hi_q <= '0;
			lo_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!res_valid_q || !res_stall)) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= cmd.mode ? ST_EXEC : ST_START;
					end
				end
				ST_START: begin
					pc_q <= cmd_q.start_address;
					ds_q <= cmd_q.start_address + 32'd4;
					state_q <= ST_OUT;
				end
				ST_EXEC: begin
					if (ex_inv) begin
						state_q <= ST_OUT;
					end else begin
						pc_q <= ds_q;
						ds_q <= ex_ds;
						if (ex_kind == K_MD) begin
							state_q <= ST_MD;
						end else if (ex_kind == K_MEM) begin
							state_q <= POW2 ? ST_MRD : ST_IDX;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_MD: begin
					if (md_rsp.done) begin
						hi_q <= md_rsp.hi;
						lo_q <= md_rsp.lo;
						state_q <= ST_OUT;
					end
				end
				ST_IDX: begin
					if (md_rsp.done) begin
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MEM;
				end
				ST_MEM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || !res_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			inv_q <= 1'b0;
			st_valid_q <= 1'b0;
			st_half_q <= 1'b0;
			st_addr_q <= '0;
			st_data_q <= '0;
		end
		if (state_q == ST_EXEC) begin
			inv_q <= ex_inv;
			ea_q <= ea;
			idx_q <= ea[AW+1:2];
			if (op == mseu_pkg::OP_SH || op == mseu_pkg::OP_SW) begin
				st_valid_q <= 1'b1;
				st_half_q <= (op == mseu_pkg::OP_SH);
				st_addr_q <= ea;
				st_data_q <= (op == mseu_pkg::OP_SH) ? {16'd0, rt_d[15:0]} : rt_d;
			end
		end
		if (state_q == ST_IDX && md_rsp.done) begin
			idx_q <= md_rsp.hi[AW-1:0];
		end
		if (state_q == ST_OUT && (!res_valid_q || !res_stall)) begin
			res_q.fetch_address <= pc_q;
			res_q.finished <= (pc_q == mseu_pkg::RETURN_MARKER);
			res_q.invalid_op <= inv_q;
			res_q.store_valid <= st_valid_q;
			res_q.store_half <= st_half_q;
			res_q.store_address <= st_addr_q;
			res_q.store_data <= st_data_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_md_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == ST_MD || state_q == ST_IDX))
		else $error("multiply/divide result outside a wait state");

	a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRD || state_q == ST_MEM) |-> !dm_busy)
		else $error("data memory access during clearing pass");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cmd_stall && state_q != ST_IDLE))
		else $error("item accepted but sequencer did not leave idle");

	a_result_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !(res_valid_q && res_stall)) |=> res_valid_q)
		else $error("finished item not presented");
endmodule
`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking bench for mips_subset_execute_unit_core
// predicts each result with an architectural model of pc, registers, hi/lo and data memory
// depends on mseu_pkg and the core rtl
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mseu_pkg::*;

	localparam int DW = 1024;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res;

	mips_subset_execute_unit_core #(.DATA_WORDS(DW)) DUT (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// architectural state of the predictor
	logic [31:0] gpr [32];
	logic [31:0] hi_q, lo_q, pc_q, next_pc_q;
	logic [31:0] dmem [DW];
	res_item_t   pending_results [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          hold_off = 1'b0;
	int          stall_mode = 0;

	function automatic logic [31:0] sx16(logic [31:0] v);
		return {{16{v[15]}}, v[15:0]};
	endfunction

	function automatic res_item_t execute_item(cmd_item_t c);
		res_item_t   r;
		logic [5:0]  op, fn;
		logic [4:0]  rsn, rtn, rdn, sa;
		logic [31:0] rs, rt, imm_s, imm_u, ea, old_pc, old_np, w, wr;
		logic [63:0] prod;
		logic        bad, wen;
		logic [4:0]  wn;
		int          idx;
		r = '0;
		bad = 1'b0;
		wen = 1'b0;
		wn = '0;
		wr = '0;
		if (c.mode == 1'b0) begin
			pc_q = c.start_address;
			next_pc_q = c.start_address + 32'd4;
			gpr[REG_RA] = RETURN_MARKER;
		end else begin
			op = c.instruction_word[31:26];
			rsn = c.instruction_word[25:21];
			rtn = c.instruction_word[20:16];
			rdn = c.instruction_word[15:11];
			sa = c.instruction_word[10:6];
			fn = c.instruction_word[5:0];
			rs = gpr[rsn];
			rt = gpr[rtn];
			imm_u = {16'h0, c.instruction_word[15:0]};
			imm_s = sx16(c.instruction_word);
			ea = rs + imm_s;
			idx = int'((ea >> 2) % DW);
			old_pc = pc_q;
			old_np = next_pc_q;
			pc_q = next_pc_q;
			next_pc_q = next_pc_q + 32'd4;
			case (op)
				OP_SPECIAL: begin
					case (fn)
						FN_SLL: begin wen = 1; wn = rdn; wr = rt << sa; end
						FN_SRA: begin wen = 1; wn = rdn; wr = $signed(rt) >>> sa; end
						FN_SLLV: begin wen = 1; wn = rdn; wr = rt << rs[4:0]; end
						FN_JR: next_pc_q = rs;
						FN_JALR: begin wen = 1; wn = rdn; wr = next_pc_q; next_pc_q = rs; end
						FN_MFHI: begin wen = 1; wn = rdn; wr = hi_q; end
						FN_MFLO: begin wen = 1; wn = rdn; wr = lo_q; end
						FN_MULT: begin
							prod = $signed({{32{rs[31]}}, rs}) * $signed({{32{rt[31]}}, rt});
							hi_q = prod[63:32];
							lo_q = prod[31:0];
						end
						FN_DIV: begin
							if (rt == 0) begin
								lo_q = rs[31] ? 32'd1 : 32'hFFFFFFFF;
								hi_q = rs;
							end else if (rs == 32'h80000000 && rt == 32'hFFFFFFFF) begin
								lo_q = 32'h80000000;
								hi_q = 32'd0;
							end else begin
								lo_q = $signed(rs) / $signed(rt);
								hi_q = $signed(rs) % $signed(rt);
							end
						end
						FN_ADDU: begin wen = 1; wn = rdn; wr = rs + rt; end
						FN_SUB, FN_SUBU: begin wen = 1; wn = rdn; wr = rs - rt; end
						FN_AND: begin wen = 1; wn = rdn; wr = rs & rt; end
						FN_OR: begin wen = 1; wn = rdn; wr = rs | rt; end
						FN_XOR: begin wen = 1; wn = rdn; wr = rs ^ rt; end
						FN_SLT: begin wen = 1; wn = rdn; wr = {31'h0, $signed(rs) < $signed(rt)}; end
						default: bad = 1'b1;
					endcase
				end
				OP_REGIMM: begin
					if (rtn == RT_BGEZ) begin
						if (!rs[31]) next_pc_q = pc_q + (imm_s << 2);
					end else begin
						bad = 1'b1;
					end
				end
				OP_BEQ: if (rs == rt) next_pc_q = pc_q + (imm_s << 2);
				OP_BNE: if (rs != rt) next_pc_q = pc_q + (imm_s << 2);
				OP_ADDIU: begin wen = 1; wn = rtn; wr = rs + imm_s; end
				OP_SLTI: begin wen = 1; wn = rtn; wr = {31'h0, $signed(rs) < $signed(imm_s)}; end
				OP_SLTIU: begin wen = 1; wn = rtn; wr = {31'h0, rs < imm_s}; end
				OP_ANDI: begin wen = 1; wn = rtn; wr = rs & imm_u; end
				OP_ORI: begin wen = 1; wn = rtn; wr = rs | imm_u; end
				OP_XORI: begin wen = 1; wn = rtn; wr = rs ^ imm_u; end
				OP_LUI: begin wen = 1; wn = rtn; wr = imm_u << 16; end
				OP_LH: begin
					w = dmem[idx];
					wen = 1; wn = rtn; wr = sx16(ea[1] ? (w >> 16) : w);
				end
				OP_LW: begin wen = 1; wn = rtn; wr = dmem[idx]; end
				OP_SH: begin
					if (ea[1]) dmem[idx][31:16] = rt[15:0];
					else dmem[idx][15:0] = rt[15:0];
					r.store_valid = 1; r.store_half = 1;
					r.store_address = ea; r.store_data = {16'h0, rt[15:0]};
				end
				OP_SW: begin
					dmem[idx] = rt;
					r.store_valid = 1; r.store_address = ea; r.store_data = rt;
				end
				default: bad = 1'b1;
			endcase
			if (wen && wn != 0) gpr[wn] = wr;
			if (bad) begin
				pc_q = old_pc;
				next_pc_q = old_np;
			end
			r.invalid_op = bad;
		end
		r.fetch_address = pc_q;
		r.finished = (pc_q == RETURN_MARKER);
		return r;
	endfunction

	// sender: one item, with bursty gaps
	task automatic send_item(cmd_item_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pending_results.push_back(execute_item(c));
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] enc_r(logic [5:0] fn, int rs, int rt, int rd, int sa);
		return {OP_SPECIAL, 5'(rs), 5'(rt), 5'(rd), 5'(sa), fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, int rs, int rt, logic [15:0] imm);
		return {op, 5'(rs), 5'(rt), imm};
	endfunction

	task automatic send_start(logic [31:0] a);
		cmd_item_t c;
		c.mode = 1'b0;
		c.instruction_word = $urandom;
		c.start_address = a;
		send_item(c);
	endtask

	task automatic send_insn(logic [31:0] w);
		cmd_item_t c;
		c.mode = 1'b1;
		c.instruction_word = w;
		c.start_address = $urandom;
		send_item(c);
	endtask

	// result checker
	always @(posedge clk) begin
		res_item_t e;
		if (res_valid && !res_stall && arst_n) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %p", res);
			end else begin
				e = pending_results.pop_front();
				if (res.fetch_address !== e.fetch_address || res.finished !== e.finished ||
					res.invalid_op !== e.invalid_op || res.store_valid !== e.store_valid ||
					res.store_half !== e.store_half || res.store_address !== e.store_address ||
					res.store_data !== e.store_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", e, res);
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (hold_off) res_stall <= 1'b1;
		else case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 1) == 0);
		endcase
		if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
	end

	task automatic test_directed();
		send_start(32'h0000_1000);
		send_insn(enc_i(OP_LUI, 0, 1, 16'h8000));
		send_insn(enc_i(OP_ORI, 1, 1, 16'hFFFF));
		send_insn(enc_i(OP_ADDIU, 0, 2, 16'hFFFF));
		send_insn(enc_r(FN_SRA, 0, 1, 3, 31));
		send_insn(enc_r(FN_SLLV, 1, 2, 4, 0));
		send_insn(enc_r(FN_SUB, 0, 1, 5, 0));
		send_insn(enc_i(OP_SLTIU, 0, 6, 16'hFFFF));
		send_insn(enc_r(FN_DIV, 1, 0, 0, 0));
		send_insn(enc_r(FN_MFLO, 0, 0, 7, 0));
		send_insn(enc_i(OP_LUI, 0, 8, 16'h8000));
		send_insn(enc_r(FN_DIV, 8, 2, 0, 0));
		send_insn(enc_r(FN_MFHI, 0, 0, 9, 0));
		send_insn(enc_r(FN_MULT, 8, 8, 0, 0));
		send_insn(enc_i(OP_SW, 0, 1, 16'hFFFE));
		send_insn(enc_i(OP_SH, 0, 2, 16'h0002));
		send_insn(enc_i(OP_LH, 0, 10, 16'h0002));
		send_insn(enc_i(OP_LW, 0, 11, 16'h0000));
		send_insn(32'hFC00_0000);
		send_insn(enc_i(OP_REGIMM, 0, 2, 16'h0004));
		send_insn(enc_r(FN_JR, 31, 0, 0, 0));
		send_insn(enc_r(FN_SLL, 0, 0, 0, 0));
		send_insn(enc_r(FN_SLL, 0, 0, 0, 0));
	endtask

	function automatic logic [31:0] random_insn();
		logic [5:0] ops [15] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_BEQ,
			OP_BNE, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LH, OP_SW, OP_SH};
		logic [5:0] fns [16] = '{FN_SLL, FN_SRA, FN_SLLV, FN_JR, FN_JALR, FN_MFHI, FN_MFLO,
			FN_MULT, FN_DIV, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_SLT};
		logic [31:0] w;
		int k;
		w = $urandom;
		k = $urandom_range(0, 19);
		if (k >= 15) begin
			if (k == 15) w[31:26] = OP_XORI;
			else if (k == 16) w[31:26] = OP_LW;
			else if (k == 17) w[31:26] = OP_ADDIU;
			// else fully random word, mostly unsupported
		end else begin
			w[31:26] = ops[k];
			if (ops[k] == OP_SPECIAL) w[5:0] = fns[$urandom_range(0, 15)];
			if (ops[k] == OP_REGIMM && $urandom_range(0, 3) != 0) w[20:16] = RT_BGEZ;
		end
		if ($urandom_range(0, 3) != 0) w[25:21] = $urandom_range(0, 7);
		if ($urandom_range(0, 3) != 0) w[20:16] = (w[31:26] == OP_REGIMM) ? w[20:16]
			: 5'($urandom_range(0, 7));
		return w;
	endfunction

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 60) == 0) send_start($urandom_range(0, 1) ? $urandom : 32'h0);
			else send_insn(random_insn());
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin repeat (300) @(negedge clk); hold_off = 1'b0; end
			test_random(30);
		join
	endtask

	initial begin
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		for (int i = 0; i < DW; i++) dmem[i] = '0;
		hi_q = '0; lo_q = '0; pc_q = '0; next_pc_q = 32'd4;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(1400);
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("sent %0d items, checked %0d results across all instruction classes",
			items_sent, results_seen);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
rtl/core/mseu_pkg.sv
rtl/core/mseu_regfile.sv
rtl/core/mseu_muldiv.sv
rtl/core/mseu_dmem.sv
rtl/core/mips_subset_execute_unit_core.sv
tb/tb_top.sv
